/* rtl/rrts_pkg.sv */
// Shared types and constants of the round-robin task scheduler.
package rrts_pkg;

    localparam int NUM_LEVELS  = 8;
    localparam int LEVEL_W     = 3;
    localparam int SPAWN_LEVEL = 4;

    typedef enum logic [2:0] {
        MODE_TICK    = 3'd0,
        MODE_YIELD   = 3'd1,
        MODE_DELAY   = 3'd2,
        MODE_SUSPEND = 3'd3,
        MODE_RESUME  = 3'd4,
        MODE_SETLVL  = 3'd5,
        MODE_SPAWN   = 3'd6,
        MODE_CANCEL  = 3'd7
    } t_mode;

    typedef enum logic [2:0] {
        STS_OK             = 3'd0,
        STS_NOT_FOUND      = 3'd1,
        STS_CANNOT_REMOVE  = 3'd2,
        STS_CANNOT_SUSPEND = 3'd3,
        STS_CANNOT_RESUME  = 3'd4,
        STS_NO_TASKS       = 3'd5,
        STS_TABLE_FULL     = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        TS_READY     = 2'd0,
        TS_RUNNING   = 2'd1,
        TS_BLOCKED   = 2'd2,
        TS_SUSPENDED = 2'd3
    } t_tstate;

    // Datapath operation issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_EXEC,
        OP_SHORT,
        OP_TICK,
        OP_DISP0,
        OP_SCAN,
        OP_FALL,
        OP_SKIP,
        OP_NEXT,
        OP_FIN,
        OP_OUT
    } t_op;

    typedef struct packed {
        logic need_disp;
        logic timer;
        logic tick_last;
        logic scan_hit;
        logic scan_last;
        logic skip_go;
        logic next_hit;
        logic out_free;
    } t_dp_stat;

    typedef struct packed {
        logic [2:0]  mode;
        logic [3:0]  task_req;
        logic [2:0]  level;
        logic [15:0] delay_ticks;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  active_task;
        logic        current_valid;
        logic [3:0]  spawned_task;
        logic [7:0]  slice_left;
        logic        still_delayed;
        logic [31:0] tick_count;
    } t_out_item;

endpackage

/* rtl/rrts_ctrl.sv */
// Sequencing state machine of the scheduler.
module rrts_ctrl
    import rrts_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_op      o_op
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_EXEC  = 11'b000_0000_0010,
        S_SHORT = 11'b000_0000_0100,
        S_TICKW = 11'b000_0000_1000,
        S_DISP0 = 11'b000_0001_0000,
        S_SCAN  = 11'b000_0010_0000,
        S_FALL  = 11'b000_0100_0000,
        S_SKIP  = 11'b000_1000_0000,
        S_NEXT  = 11'b001_0000_0000,
        S_FIN   = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // Pick the datapath operation and the next state
    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op    = OP_LATCH;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_op    = OP_EXEC;
                n_state = i_stat.need_disp ? S_SHORT : S_DONE;
            end
            S_SHORT: begin
                o_op    = OP_SHORT;
                n_state = i_stat.timer ? S_TICKW : S_DISP0;
            end
            S_TICKW: begin
                o_op = OP_TICK;
                if (i_stat.tick_last) n_state = S_DISP0;
            end
            S_DISP0: begin
                o_op    = OP_DISP0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                o_op = OP_SCAN;
                if (i_stat.scan_hit)       n_state = S_SKIP;
                else if (i_stat.scan_last) n_state = S_FALL;
            end
            S_FALL: begin
                o_op    = OP_FALL;
                n_state = S_SKIP;
            end
            S_SKIP: begin
                o_op    = OP_SKIP;
                n_state = i_stat.skip_go ? S_NEXT : S_FIN;
            end
            S_NEXT: begin
                o_op = OP_NEXT;
                if (i_stat.next_hit) n_state = S_SKIP;
            end
            S_FIN: begin
                o_op    = OP_FIN;
                n_state = S_DONE;
            end
            S_DONE: begin
                o_op = OP_OUT;
                if (i_stat.out_free) n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

endmodule

/* rtl/rrts_dp.sv */
// Task table, configuration registers and command datapath of the scheduler.
module rrts_dp
    import rrts_pkg::*;
#(
    parameter int MAX_TASKS  = 16,
    parameter int SKIP_LIMIT = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_op         i_op,
    output t_dp_stat    o_stat,
    input  t_in_item    i_in,
    input  logic        i_cfg_valid,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out
);

    localparam int AW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int KW = $clog2(SKIP_LIMIT + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_TASKS - 1);

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] x);
        return (x == LAST_SLOT) ? '0 : x + 1'b1;
    endfunction

    // Task table
    logic [MAX_TASKS-1:0] r_valid;
    t_tstate              r_tstate [MAX_TASKS];
    logic [15:0]          r_delay  [MAX_TASKS];
    logic [LEVEL_W-1:0]   r_prio   [MAX_TASKS];
    logic [7:0]           r_slice  [MAX_TASKS];

    logic [7:0]    r_cfg [NUM_LEVELS];
    t_mode         r_mode;
    logic [3:0]    r_req;
    logic [2:0]    r_lvl;
    logic [15:0]   r_dly;
    t_status       r_status;
    logic [AW-1:0] r_spawned;
    logic          r_timer;
    logic [AW-1:0] r_cur;
    logic          r_present;
    logic [31:0]   r_tick;
    logic [AW-1:0] r_idx;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] r_sel;
    logic [KW-1:0] r_att;

    logic [AW-1:0] tgt, free_slot, low_slot, addr;
    logic          known, has_free;

    assign tgt   = AW'(r_req);
    assign known = (32'(r_req) < MAX_TASKS) && r_valid[tgt];

    // Find the first free and the lowest valid slot
    always_comb begin
        free_slot = '0;
        has_free  = 1'b0;
        low_slot  = '0;
        for (int i = MAX_TASKS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_slot = AW'(i);
                has_free  = 1'b1;
            end
            if (r_valid[i]) low_slot = AW'(i);
        end
    end

    // Select the single table address of this cycle
    always_comb begin
        case (i_op)
            OP_EXEC: begin
                if (r_mode == MODE_TICK || r_mode == MODE_YIELD || r_mode == MODE_DELAY)
                    addr = r_cur;
                else if (r_mode == MODE_SPAWN)
                    addr = free_slot;
                else
                    addr = tgt;
            end
            OP_TICK, OP_SCAN, OP_NEXT: addr = r_idx;
            OP_SKIP, OP_FIN:           addr = r_sel;
            default:                   addr = r_cur;
        endcase
    end

    t_tstate            rd_state;
    logic [15:0]        rd_delay;
    logic [LEVEL_W-1:0] rd_prio;
    logic [7:0]         rd_slice;
    logic               rd_valid;

    assign rd_state = r_tstate[addr];
    assign rd_delay = r_delay[addr];
    assign rd_prio  = r_prio[addr];
    assign rd_slice = r_slice[addr];
    assign rd_valid = r_valid[addr];

    // Write strobes and data for the table entry at addr
    logic               we_state, we_delay, we_prio, we_slice, we_set, we_clr;
    t_tstate            wd_state;
    logic [15:0]        wd_delay;
    logic [LEVEL_W-1:0] wd_prio;
    logic [7:0]         wd_slice;
    logic [15:0]        dec_delay;
    logic [7:0]         dec_slice;

    t_status       n_status;
    logic [AW-1:0] n_spawned, n_cur, n_idx, n_sel;
    logic          n_timer, n_present;
    logic [31:0]   n_tick;
    logic [CW-1:0] n_cnt;
    logic [KW-1:0] n_att;
    logic          need_disp, scan_hit, skip_go, next_hit, out_free;

    assign dec_delay = rd_delay - 16'd1;
    assign dec_slice = (rd_slice != 8'd0) ? rd_slice - 8'd1 : 8'd0;
    assign out_free  = !o_out_valid || i_out_ready;

    always_comb begin
        we_state  = 1'b0;
        we_delay  = 1'b0;
        we_prio   = 1'b0;
        we_slice  = 1'b0;
        we_set    = 1'b0;
        we_clr    = 1'b0;
        wd_state  = TS_READY;
        wd_delay  = r_dly;
        wd_prio   = r_lvl;
        wd_slice  = r_cfg[rd_prio];
        n_status  = r_status;
        n_spawned = r_spawned;
        n_cur     = r_cur;
        n_present = r_present;
        n_timer   = r_timer;
        n_tick    = r_tick;
        n_idx     = r_idx;
        n_cnt     = r_cnt;
        n_sel     = r_sel;
        n_att     = r_att;
        need_disp = 1'b0;
        scan_hit  = 1'b0;
        skip_go   = 1'b0;
        next_hit  = 1'b0;
        case (i_op)
            OP_LATCH: begin
                n_status  = STS_OK;
                n_spawned = '0;
            end
            OP_EXEC: begin
                n_timer = (r_mode == MODE_TICK);
                unique case (r_mode)
                    MODE_TICK, MODE_YIELD: begin
                        if (r_mode == MODE_TICK) n_tick = r_tick + 32'd1;
                        if (!r_present) n_status = STS_NO_TASKS;
                        else            need_disp = 1'b1;
                    end
                    MODE_DELAY: begin
                        if (r_dly != 16'd0) begin
                            if (!r_present) begin
                                n_status = STS_NO_TASKS;
                            end else begin
                                we_delay  = 1'b1;
                                we_state  = 1'b1;
                                wd_state  = TS_BLOCKED;
                                need_disp = 1'b1;
                            end
                        end
                    end
                    MODE_SUSPEND: begin
                        if (!known) begin
                            n_status = STS_NOT_FOUND;
                        end else if (rd_state == TS_SUSPENDED) begin
                            n_status = STS_CANNOT_SUSPEND;
                        end else begin
                            we_state  = 1'b1;
                            wd_state  = TS_SUSPENDED;
                            need_disp = r_present && (r_cur == tgt);
                        end
                    end
                    MODE_RESUME: begin
                        if (!known)                         n_status = STS_NOT_FOUND;
                        else if (rd_state != TS_SUSPENDED)  n_status = STS_CANNOT_RESUME;
                        else                                we_state = 1'b1;
                    end
                    MODE_SETLVL: begin
                        if (!known) begin
                            n_status = STS_NOT_FOUND;
                        end else begin
                            we_prio  = 1'b1;
                            we_slice = 1'b1;
                            wd_slice = r_cfg[r_lvl];
                        end
                    end
                    MODE_SPAWN: begin
                        if (!has_free) begin
                            n_status = STS_TABLE_FULL;
                        end else begin
                            n_spawned = free_slot;
                            we_set    = 1'b1;
                            we_delay  = 1'b1;
                            wd_delay  = 16'd0;
                            we_prio   = 1'b1;
                            wd_prio   = LEVEL_W'(SPAWN_LEVEL);
                            we_slice  = 1'b1;
                            wd_slice  = r_cfg[SPAWN_LEVEL];
                            we_state  = 1'b1;
                            if (!r_present) begin
                                n_present = 1'b1;
                                n_cur     = free_slot;
                            end
                        end
                    end
                    MODE_CANCEL: begin
                        if (r_present && (32'(r_req) == 32'(r_cur)))
                            n_status = STS_CANNOT_REMOVE;
                        else if (!known)
                            n_status = STS_NOT_FOUND;
                        else if (rd_state == TS_RUNNING)
                            n_status = STS_CANNOT_REMOVE;
                        else
                            we_clr = 1'b1;
                    end
                endcase
            end
            OP_SHORT: begin
                // Shorten the current slice; an expired running task becomes ready
                we_slice = 1'b1;
                wd_slice = dec_slice;
                if (dec_slice == 8'd0 && rd_state == TS_RUNNING) we_state = 1'b1;
                n_idx = '0;
            end
            OP_TICK: begin
                // Count down one blocked delay and wake the task at zero
                if (rd_valid && rd_state == TS_BLOCKED && rd_delay != 16'd0) begin
                    we_delay = 1'b1;
                    wd_delay = dec_delay;
                    if (dec_delay == 16'd0) begin
                        we_state = 1'b1;
                        we_slice = 1'b1;
                    end
                end
                n_idx = wrap_inc(r_idx);
            end
            OP_DISP0: begin
                if (rd_state == TS_RUNNING) we_state = 1'b1;
                n_idx = wrap_inc(r_cur);
                n_cnt = CW'(1);
                n_att = '0;
            end
            OP_SCAN: begin
                if (rd_valid && rd_state == TS_READY) begin
                    scan_hit = 1'b1;
                    n_sel    = r_idx;
                    we_state = 1'b1;
                    wd_state = TS_RUNNING;
                    we_slice = 1'b1;
                end else begin
                    n_idx = wrap_inc(r_idx);
                    n_cnt = r_cnt + 1'b1;
                end
            end
            OP_FALL: begin
                n_sel = low_slot;
            end
            OP_SKIP: begin
                // Skip a chosen task that still holds a delay, at most SKIP_LIMIT times per dispatch
                if (rd_delay != 16'd0 && 32'(r_att) < SKIP_LIMIT) begin
                    skip_go = 1'b1;
                    n_att   = r_att + 1'b1;
                    n_idx   = wrap_inc(r_sel);
                end
            end
            OP_NEXT: begin
                if (rd_valid) begin
                    next_hit = 1'b1;
                    n_sel    = r_idx;
                end else begin
                    n_idx = wrap_inc(r_idx);
                end
            end
            OP_FIN: begin
                we_state = 1'b1;
                wd_state = TS_RUNNING;
                we_slice = 1'b1;
                n_cur    = r_sel;
            end
            default: begin
            end
        endcase
    end

    assign o_stat.need_disp = need_disp;
    assign o_stat.timer     = r_timer;
    assign o_stat.tick_last = (r_idx == LAST_SLOT);
    assign o_stat.scan_hit  = scan_hit;
    assign o_stat.scan_last = (32'(r_cnt) == MAX_TASKS);
    assign o_stat.skip_go   = skip_go;
    assign o_stat.next_hit  = next_hit;
    assign o_stat.out_free  = out_free;

    // Table payload: written at one address, no reset
    always_ff @(posedge i_clk) begin
        if (we_state) r_tstate[addr] <= wd_state;
        if (we_delay) r_delay[addr]  <= wd_delay;
        if (we_prio)  r_prio[addr]   <= wd_prio;
        if (we_slice) r_slice[addr]  <= wd_slice;
    end

    // Command latch and walk registers
    always_ff @(posedge i_clk) begin
        if (i_op == OP_LATCH) begin
            r_mode <= t_mode'(i_in.mode);
            r_req  <= i_in.task_req;
            r_lvl  <= i_in.level;
            r_dly  <= i_in.delay_ticks;
        end
        r_status  <= n_status;
        r_spawned <= n_spawned;
        r_timer   <= n_timer;
        r_idx     <= n_idx;
        r_cnt     <= n_cnt;
        r_sel     <= n_sel;
        r_att     <= n_att;
    end

    // Control state, configuration and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_cur       <= '0;
            r_present   <= 1'b0;
            r_tick      <= '0;
            o_out_valid <= 1'b0;
            for (int i = 0; i < NUM_LEVELS; i++) r_cfg[i] <= 8'(i + 1);
        end else begin
            if (we_set) r_valid[addr] <= 1'b1;
            if (we_clr) r_valid[addr] <= 1'b0;
            r_cur     <= n_cur;
            r_present <= n_present;
            r_tick    <= n_tick;
            if (i_cfg_valid) r_cfg[i_cfg_index] <= i_cfg_data;
            if (i_op == OP_OUT && out_free) o_out_valid <= 1'b1;
            else if (i_out_ready)           o_out_valid <= 1'b0;
        end
    end

    // Capture the result transfer: status, current task fields, spawned slot and tick count
    always_ff @(posedge i_clk) begin
        if (i_op == OP_OUT && out_free) begin
            o_out.status        <= r_status;
            o_out.active_task   <= r_present ? 4'(r_cur) : 4'd0;
            o_out.current_valid <= r_present;
            o_out.spawned_task  <= 4'(r_spawned);
            o_out.slice_left    <= r_present ? rd_slice : 8'd0;
            o_out.still_delayed <= r_present && (rd_delay != 16'd0);
            o_out.tick_count    <= r_tick;
        end
    end

endmodule

/* rtl/round_robin_task_scheduler.sv */
// Round-robin task scheduler: one command at a time, one result transfer per command.
// Steps: latch, execute, then the result unless a dispatch is needed. A dispatch shortens
// the current slice, walks every slot's delay on a tick, scans the slots for a ready task
// (fallback: lowest valid slot) and skips delayed picks up to SKIP_LIMIT times.
// The next command is taken in the cycle after the result is captured; a stalled result
// holds it. Reset (synchronous, active low) clears slots, current task and tick count.
module round_robin_task_scheduler
    import rrts_pkg::*;
#(
    parameter int MAX_TASKS  = 16,
    parameter int SKIP_LIMIT = 10
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    t_op      op;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    rrts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_op       (op)
    );

    rrts_dp #(
        .MAX_TASKS  (MAX_TASKS),
        .SKIP_LIMIT (SKIP_LIMIT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .o_stat      (stat),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule
